FILE: hdl/int_float_sample_converter_macros.svh
// Assertion macros used by the sample converter top module
`ifndef INT_FLOAT_SAMPLE_CONVERTER_MACROS_SVH
`define INT_FLOAT_SAMPLE_CONVERTER_MACROS_SVH
// Implication check on a clock with synchronous reset
`define IFSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication check
`define IFSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: hdl/ifsc_pkg.sv
// Shared types, codes and helpers of the sample converter
package ifsc_pkg;
   typedef enum logic [1:0] {
      FMT_U8  = 2'd0,
      FMT_U16 = 2'd1,
      FMT_F32 = 2'd2,
      FMT_F64 = 2'd3
   } fmt_type;

   localparam int SampleWidth = 64;
   localparam int CsrAddrWidth = 1;
   localparam logic [CsrAddrWidth-1:0] CSR_SOURCE_FORMAT = 1'b0;
   localparam logic [CsrAddrWidth-1:0] CSR_DEST_FORMAT   = 1'b1;

   typedef enum logic [1:0] {
      OP_PASS  = 2'd0,
      OP_UNSUP = 2'd1,
      OP_I2F   = 2'd2,
      OP_F2I   = 2'd3
   } op_type;

   // Decoded fields handed from the front stage to the back stage
   typedef struct packed {
      op_type     op;
      logic       dst_dbl;
      logic       dst_u16;
      logic       last;
      logic [63:0] pass;    // masked pass-through value
      // integer path
      logic [15:0] ival;
      logic [3:0]  lead;    // position of leading one
      logic        izero;
      // float path
      logic        fzero;   // NaN, negative or below one
      logic        fsat;    // infinity or above integer range
      logic [3:0]  fpow;    // unbiased exponent, 0..15
      logic [14:0] fman;    // top mantissa bits
   } dec_type;

   function automatic logic [63:0] fmt_mask(input fmt_type f);
      logic [63:0] m;
      unique case (f)
         FMT_U8:  m = 64'h0000_0000_0000_00FF;
         FMT_U16: m = 64'h0000_0000_0000_FFFF;
         FMT_F32: m = 64'h0000_0000_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction
endpackage

FILE: hdl/int_float_sample_converter.sv
// Sample converter: uint8/uint16 to and from IEEE single/double, one sample a cycle
// while rsp_tready stays high. Stages: input register, decode register, result register.
// Config may be written only while the pipeline is empty.
`include "int_float_sample_converter_macros.svh"
module int_float_sample_converter
   import ifsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // sample_in
   input  logic        req_tlast,  // last_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // sample_out
   output logic [1:0]  rsp_tuser,  // saturated (bit 1), unsupported (bit 0)
   output logic        rsp_tlast,  // last_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CsrAddrWidth-1:0] csr_index,
   input  logic [1:0]  csr_data
);
   fmt_type src_ff, dst_ff;
   logic v0_ff, v1_ff, v2_ff;
   logic [63:0] s0_ff;
   logic l0_ff;
   dec_type d1_ff, d1_in;
   logic [63:0] r_in, r_ff;
   logic u_in, t_in, u_ff, t_ff, l2_ff;
   logic en0, en1, en2;

   assign csr_ready = 1'b1;
   // advance when the next stage is free
   assign en2 = !v2_ff || rsp_tready;
   assign en1 = !v1_ff || en2;
   assign en0 = !v0_ff || en1;
   assign req_tready = en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= FMT_U8; dst_ff <= FMT_F32;
      end else if (csr_valid) begin
         if (csr_index == CSR_SOURCE_FORMAT) src_ff <= fmt_type'(csr_data);
         else dst_ff <= fmt_type'(csr_data);
      end
   end

   ifsc_decode u_dec (.src_fmt(src_ff), .dst_fmt(dst_ff), .sample(s0_ff),
                      .last(l0_ff), .dec(d1_in));
   ifsc_assemble u_asm (.dec(d1_ff), .sample(r_in), .unsup(u_in), .sat(t_in));

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= req_tvalid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en0) begin
         s0_ff <= req_tdata; l0_ff <= req_tlast;
      end
      if (en1) d1_ff <= d1_in;
      if (en2) begin
         r_ff <= r_in & fmt_mask(d1_ff.dst_dbl ? FMT_F64 : dst_ff);
         u_ff <= u_in; t_ff <= t_in; l2_ff <= d1_ff.last;
      end
   end

   assign rsp_tvalid = v2_ff;
   assign rsp_tdata = r_ff;
   assign rsp_tuser = {t_ff, u_ff};
   assign rsp_tlast = l2_ff;

   `IFSC_ASSERT_IMP(a_flags_excl, clock, reset, rsp_tvalid, !(u_ff && t_ff), "both flags set")
   `IFSC_ASSERT_IMP(a_unsup_zero, clock, reset, rsp_tvalid && u_ff, r_ff == 64'd0, "unsup nonzero")
   `IFSC_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped")
endmodule

FILE: hdl/ifsc_decode.sv
// Front stage: operation select, field split and exponent classification
module ifsc_decode
   import ifsc_pkg::*;
(
   input  fmt_type     src_fmt,
   input  fmt_type     dst_fmt,
   input  logic [63:0] sample,
   input  logic        last,
   output dec_type     dec
);
   logic [63:0] s;
   logic        sign;
   logic [10:0] e;
   logic        mnz;
   logic        emax;
   logic [10:0] bias;
   logic [10:0] p;
   logic [51:0] m;

   always_comb begin
      s = sample & fmt_mask(src_fmt);
      dec = '0;
      dec.last = last;
      dec.dst_dbl = (dst_fmt == FMT_F64);
      dec.dst_u16 = (dst_fmt == FMT_U16);
      dec.pass = s;
      // select operation
      if (src_fmt == dst_fmt) dec.op = OP_PASS;
      else if (src_fmt[1] == dst_fmt[1]) dec.op = OP_UNSUP;
      else if (!src_fmt[1]) dec.op = OP_I2F;
      else dec.op = OP_F2I;
      // integer: find leading one
      dec.ival = s[15:0];
      dec.izero = (s[15:0] == 16'd0);
      for (int i = 0; i < 16; i++) begin
         if (s[i]) dec.lead = 4'(i);
      end
      // float: split encoding
      if (src_fmt == FMT_F64) begin
         sign = s[63]; e = s[62:52]; m = s[51:0];
         emax = (e == 11'h7FF); bias = 11'd1023;
      end else begin
         sign = s[31]; e = {3'b0, s[30:23]}; m = {s[22:0], 29'b0};
         emax = (e == 11'h0FF); bias = 11'd127;
      end
      mnz = (m != 52'd0);
      p = e - bias;
      dec.fman = m[51:37];
      dec.fpow = p[3:0];
      dec.fzero = (emax && mnz) || sign || (!emax && e < bias);
      dec.fsat = !dec.fzero && (emax || p >= (dec.dst_u16 ? 11'd16 : 11'd8));
   end
endmodule

FILE: hdl/ifsc_assemble.sv
// Back stage: build the result word and flags
module ifsc_assemble
   import ifsc_pkg::*;
(
   input  dec_type     dec,
   output logic [63:0] sample,
   output logic        unsup,
   output logic        sat
);
   logic [15:0] frac;
   logic [15:0] fint;
   always_comb begin
      sample = '0; unsup = 1'b0; sat = 1'b0;
      frac = dec.ival << (5'd16 - {1'b0, dec.lead});
      fint = 16'({1'b1, dec.fman} >> (5'd15 - {1'b0, dec.fpow}));
      unique case (dec.op)
         OP_PASS:  sample = dec.pass;
         OP_UNSUP: unsup = 1'b1;
         OP_I2F: begin
            if (!dec.izero) begin
               if (dec.dst_dbl)
                  sample = {1'b0, 11'(11'd1023 + 11'(dec.lead)), frac, 36'b0};
               else
                  sample = {32'b0, 1'b0, 8'(8'd127 + 8'(dec.lead)), frac, 7'b0};
            end
         end
         default: begin
            if (dec.fsat) begin
               sat = 1'b1;
               sample = dec.dst_u16 ? 64'hFFFF : 64'hFF;
            end else if (!dec.fzero) begin
               sample = {48'b0, dec.dst_u16 ? fint : {8'b0, fint[7:0]}};
            end
         end
      endcase
   end
endmodule
